>>> rtl/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants of the terminal escape sequence parser:
// event codes, command codes between the front and back parts, byte values.
// ----------------------------------------------------------------------------
package vtp_pkg;

    localparam int unsigned ArgW  = 20;
    localparam int unsigned CpW   = 21;
    localparam int unsigned RowW  = 10;
    localparam int unsigned ColW  = 12;
    localparam int unsigned KindW = 5;

    typedef enum logic [KindW-1:0] {
        EV_CONSUMED = 5'd0,
        EV_SGR      = 5'd1,
        EV_ABS      = 5'd2,
        EV_UP       = 5'd3,
        EV_DOWN     = 5'd4,
        EV_FWD      = 5'd5,
        EV_BACK     = 5'd6,
        EV_EOL      = 5'd7,
        EV_BOL      = 5'd8,
        EV_LINE     = 5'd9,
        EV_SCREEN   = 5'd10,
        EV_BOS      = 5'd11,
        EV_EOS      = 5'd12,
        EV_REGION   = 5'd13,
        EV_ROWABS   = 5'd14,
        EV_ECH      = 5'd15,
        EV_ALTIN    = 5'd16,
        EV_ALTOUT   = 5'd17,
        EV_CHAR     = 5'd18,
        EV_CR       = 5'd19,
        EV_LF       = 5'd20
    } t_event;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CHAR,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_TAB,
        OP_FINAL
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [7:0]      fin;
        logic            priv;
        logic [ArgW-1:0] p0;
        logic [ArgW-1:0] p1;
        logic [RowW-1:0] row;
        logic [3:0]      tab;
        logic [CpW-1:0]  cp;
    } t_cmd;

    localparam logic [ArgW-1:0] ACCUM_LIMIT = 20'd65535;
    localparam logic [ArgW-1:0] ALT_SCREEN  = 20'd1049;
    localparam logic [RowW-1:0] ROWS_RESET  = 10'd24;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_G0     = 8'h28;
    localparam logic [7:0] CH_G1     = 8'h29;
    localparam logic [7:0] CH_G2     = 8'h2A;
    localparam logic [7:0] CH_G3     = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_FIN_LO = 8'h40;
    localparam logic [7:0] CH_FIN_HI = 8'h7E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    localparam logic [7:0] FIN_CUU = 8'h41;
    localparam logic [7:0] FIN_CUD = 8'h42;
    localparam logic [7:0] FIN_CUF = 8'h43;
    localparam logic [7:0] FIN_CUB = 8'h44;
    localparam logic [7:0] FIN_CNL = 8'h45;
    localparam logic [7:0] FIN_CPL = 8'h46;
    localparam logic [7:0] FIN_CHA = 8'h47;
    localparam logic [7:0] FIN_CUP = 8'h48;
    localparam logic [7:0] FIN_ED  = 8'h4A;
    localparam logic [7:0] FIN_EL  = 8'h4B;
    localparam logic [7:0] FIN_ECH = 8'h58;
    localparam logic [7:0] FIN_VPA = 8'h64;
    localparam logic [7:0] FIN_HVP = 8'h66;
    localparam logic [7:0] FIN_SET = 8'h68;
    localparam logic [7:0] FIN_RST = 8'h6C;
    localparam logic [7:0] FIN_SGR = 8'h6D;
    localparam logic [7:0] FIN_STB = 8'h72;

endpackage

>>> rtl/vtp_front.sv
// ----------------------------------------------------------------------------
// vtp_front
// Byte front end: tracks escape, control, command-string and charset states,
// gathers parameters, assembles utf-8 and classifies each byte into a command.
// ----------------------------------------------------------------------------
module vtp_front import vtp_pkg::*; #(
    parameter int unsigned MAX_PARAMS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic [RowW-1:0]  i_row,
    input  logic [ColW-1:0]  i_col,
    output t_cmd             o_cmd
);

    localparam int unsigned TotW = $clog2(MAX_PARAMS + 1);

    logic            r_after_esc, n_after_esc;
    logic            r_in_csi, n_in_csi;
    logic            r_priv, n_priv;
    logic            r_in_osc, n_in_osc;
    logic            r_osc_esc, n_osc_esc;
    logic            r_skip_cs, n_skip_cs;
    logic [ArgW-1:0] r_accum, n_accum;
    logic [ArgW-1:0] r_first, n_first;
    logic [ArgW-1:0] r_second, n_second;
    logic [TotW-1:0] r_total, n_total;
    logic [2:0]      r_have, n_have;
    logic [2:0]      r_need, n_need;
    logic [7:0]      r_u8_bytes [4];

    logic            u8_we;
    logic [1:0]      u8_addr;
    logic [ArgW-1:0] cl_first, cl_second;
    logic [TotW-1:0] cl_total;
    logic [2:0]      have_inc;
    logic [ArgW-1:0] accum_x10;

    // parameter close
    always_comb begin
        cl_first  = r_first;
        cl_second = r_second;
        cl_total  = r_total;
        if (r_total < TotW'(MAX_PARAMS)) begin
            if (r_total == '0) begin
                cl_first = r_accum;
            end
            if (r_total == TotW'(1)) begin
                cl_second = r_accum;
            end
            cl_total = r_total + TotW'(1);
        end
    end

    assign have_inc  = r_have + 3'd1;
    assign accum_x10 = {r_accum[ArgW-4:0], 3'b000} + {r_accum[ArgW-2:0], 1'b0};

    always_comb begin
        n_after_esc = r_after_esc;
        n_in_csi    = r_in_csi;
        n_priv      = r_priv;
        n_in_osc    = r_in_osc;
        n_osc_esc   = r_osc_esc;
        n_skip_cs   = r_skip_cs;
        n_accum     = r_accum;
        n_first     = r_first;
        n_second    = r_second;
        n_total     = r_total;
        n_have      = r_have;
        n_need      = r_need;
        u8_we       = 1'b0;
        u8_addr     = 2'd0;
        o_cmd       = '0;
        o_cmd.op    = OP_NONE;
        o_cmd.row   = i_row;

        if (r_in_osc) begin
            if (r_osc_esc) begin
                n_osc_esc = 1'b0;
                if (i_byte == CH_BSLASH) begin
                    n_in_osc = 1'b0;
                end
            end else if (i_byte == CH_BEL) begin
                n_in_osc = 1'b0;
            end else if (i_byte == CH_ESC) begin
                n_osc_esc = 1'b1;
            end
        end else if (r_skip_cs) begin
            n_skip_cs = 1'b0;
        end else if (r_after_esc && (i_byte != CH_ESC)) begin
            n_after_esc = 1'b0;
            if (i_byte == CH_LBRACK) begin
                n_in_csi = 1'b1;
                n_priv   = 1'b0;
                n_total  = '0;
                n_accum  = '0;
            end else if (i_byte == CH_RBRACK) begin
                n_in_osc  = 1'b1;
                n_osc_esc = 1'b0;
            end else if ((i_byte == CH_G0) || (i_byte == CH_G1) ||
                         (i_byte == CH_G2) || (i_byte == CH_G3)) begin
                n_skip_cs = 1'b1;
            end
        end else if (i_byte == CH_ESC) begin
            n_after_esc = 1'b1;
            n_in_csi    = 1'b0;
            n_have      = 3'd0;
            n_need      = 3'd0;
        end else if (r_in_csi) begin
            if ((i_byte >= CH_ZERO) && (i_byte <= CH_NINE)) begin
                if (r_accum <= ACCUM_LIMIT) begin
                    n_accum = accum_x10 + {12'd0, i_byte - CH_ZERO};
                end
            end else if ((i_byte == CH_SEMI) || (i_byte == CH_COLON)) begin
                n_first  = cl_first;
                n_second = cl_second;
                n_total  = cl_total;
                n_accum  = '0;
            end else if (i_byte == CH_QUEST) begin
                n_priv = 1'b1;
            end else if ((i_byte >= CH_FIN_LO) && (i_byte <= CH_FIN_HI)) begin
                n_first    = cl_first;
                n_second   = cl_second;
                n_total    = cl_total;
                n_accum    = '0;
                n_in_csi   = 1'b0;
                o_cmd.op   = OP_FINAL;
                o_cmd.fin  = i_byte;
                o_cmd.priv = r_priv;
                o_cmd.p0   = cl_first;
                o_cmd.p1   = (cl_total > TotW'(1)) ? cl_second : '0;
            end
        end else if (i_byte == CH_CR) begin
            o_cmd.op = OP_CR;
        end else if (i_byte == CH_LF) begin
            o_cmd.op = OP_LF;
        end else if (i_byte == CH_BS) begin
            o_cmd.op = OP_BS;
        end else if (i_byte == CH_TAB) begin
            o_cmd.op  = OP_TAB;
            o_cmd.tab = 4'd8 - {1'b0, i_col[2:0]};
        end else if (i_byte < CH_SPACE) begin
            o_cmd.op = OP_NONE;
        end else if ((r_need != 3'd0) && (i_byte[7:6] == 2'b10)) begin
            // continuation byte
            u8_we   = 1'b1;
            u8_addr = r_have[1:0];
            n_have  = have_inc;
            if (have_inc >= r_need) begin
                n_have   = 3'd0;
                n_need   = 3'd0;
                o_cmd.op = OP_CHAR;
                case (r_need)
                    3'd2: o_cmd.cp = {10'd0, r_u8_bytes[0][4:0], i_byte[5:0]};
                    3'd3: o_cmd.cp = {5'd0, r_u8_bytes[0][3:0], r_u8_bytes[1][5:0],
                                      i_byte[5:0]};
                    default: o_cmd.cp = {r_u8_bytes[0][2:0], r_u8_bytes[1][5:0],
                                         r_u8_bytes[2][5:0], i_byte[5:0]};
                endcase
            end
        end else begin
            // lead byte, a broken sequence is dropped first
            n_have = 3'd0;
            n_need = 3'd0;
            if (i_byte[7] == 1'b0) begin
                o_cmd.op = OP_CHAR;
                o_cmd.cp = {13'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_need  = 3'd2;
                n_have  = 3'd1;
                u8_we   = 1'b1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_need  = 3'd3;
                n_have  = 3'd1;
                u8_we   = 1'b1;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_need  = 3'd4;
                n_have  = 3'd1;
                u8_we   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_esc <= 1'b0;
            r_in_csi    <= 1'b0;
            r_priv      <= 1'b0;
            r_in_osc    <= 1'b0;
            r_osc_esc   <= 1'b0;
            r_skip_cs   <= 1'b0;
            r_accum     <= '0;
            r_first     <= '0;
            r_second    <= '0;
            r_total     <= '0;
            r_have      <= 3'd0;
            r_need      <= 3'd0;
        end else if (i_take) begin
            r_after_esc <= n_after_esc;
            r_in_csi    <= n_in_csi;
            r_priv      <= n_priv;
            r_in_osc    <= n_in_osc;
            r_osc_esc   <= n_osc_esc;
            r_skip_cs   <= n_skip_cs;
            r_accum     <= n_accum;
            r_first     <= n_first;
            r_second    <= n_second;
            r_total     <= n_total;
            r_have      <= n_have;
            r_need      <= n_need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && u8_we) begin
            r_u8_bytes[u8_addr] <= i_byte;
        end
    end

endmodule

>>> rtl/vtp_queue.sv
// ----------------------------------------------------------------------------
// vtp_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module vtp_queue import vtp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_slot0, r_slot1;
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_rptr ? r_slot1 : r_slot0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !r_wptr) begin
            r_slot0 <= i_cmd;
        end
        if (i_push && r_wptr) begin
            r_slot1 <= i_cmd;
        end
    end

endmodule

>>> rtl/vtp_back.sv
// ----------------------------------------------------------------------------
// vtp_back
// Command back end: decodes characters, controls and final bytes with defaults and
// clamping, forms the event and holds it in the output register until transfer.
// ----------------------------------------------------------------------------
module vtp_back import vtp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [RowW-1:0]  i_cfg_data,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [KindW-1:0] o_kind,
    output logic [ArgW-1:0]  o_arg_one,
    output logic [ArgW-1:0]  o_arg_two,
    output logic [CpW-1:0]   o_cp
);

    logic [RowW-1:0]  r_rows;
    logic             r_valid;
    t_event           r_kind, n_kind;
    logic [ArgW-1:0]  r_arg_one, n_arg_one;
    logic [ArgW-1:0]  r_arg_two, n_arg_two;
    logic [CpW-1:0]   r_cp, n_cp;

    logic [ArgW-1:0]  cnt;
    logic [ArgW-1:0]  row_w;
    logic [ArgW-1:0]  p1_m1;
    logic [ArgW-1:0]  bot_base;
    logic signed [ArgW:0] bot_raw, bot, rows_s, top_s;

    assign row_w    = {{(ArgW-RowW){1'b0}}, i_cmd.row};
    assign cnt      = (i_cmd.p0 != '0) ? i_cmd.p0 : ArgW'(1);
    assign p1_m1    = ((i_cmd.p1 != '0) ? i_cmd.p1 : ArgW'(1)) - ArgW'(1);
    assign bot_base = (i_cmd.p1 != '0) ? i_cmd.p1 : {{(ArgW-RowW){1'b0}}, r_rows};
    assign rows_s   = $signed({{(ArgW+1-RowW){1'b0}}, r_rows});
    assign bot_raw  = $signed({1'b0, bot_base}) - 21'sd1;
    assign bot      = (bot_raw >= rows_s) ? (rows_s - 21'sd1) : bot_raw;
    assign top_s    = $signed({1'b0, cnt - ArgW'(1)});

    always_comb begin
        n_kind    = EV_CONSUMED;
        n_arg_one = '0;
        n_arg_two = '0;
        n_cp      = '0;
        case (i_cmd.op)
            OP_CHAR: begin
                n_kind = EV_CHAR;
                n_cp   = i_cmd.cp;
            end
            OP_CR:   n_kind = EV_CR;
            OP_LF:   n_kind = EV_LF;
            OP_BS:   n_kind = EV_BACK;
            OP_TAB: begin
                n_kind    = EV_FWD;
                n_arg_one = {16'd0, i_cmd.tab};
            end
            OP_FINAL: begin
                if (i_cmd.priv) begin
                    if ((i_cmd.p0 == ALT_SCREEN) && (i_cmd.fin == FIN_SET)) begin
                        n_kind = EV_ALTIN;
                    end else if ((i_cmd.p0 == ALT_SCREEN) && (i_cmd.fin == FIN_RST)) begin
                        n_kind = EV_ALTOUT;
                    end
                end else begin
                    case (i_cmd.fin)
                        FIN_SGR: n_kind = EV_SGR;
                        FIN_CUP, FIN_HVP: begin
                            n_kind    = EV_ABS;
                            n_arg_one = cnt - ArgW'(1);
                            n_arg_two = p1_m1;
                        end
                        FIN_CUU: begin
                            n_kind    = EV_UP;
                            n_arg_one = cnt;
                        end
                        FIN_CUD: begin
                            n_kind    = EV_DOWN;
                            n_arg_one = cnt;
                        end
                        FIN_CUF: begin
                            n_kind    = EV_FWD;
                            n_arg_one = cnt;
                        end
                        FIN_CUB: begin
                            n_kind    = EV_BACK;
                            n_arg_one = cnt;
                        end
                        FIN_CNL: begin
                            n_kind    = EV_ABS;
                            n_arg_one = row_w + cnt;
                        end
                        FIN_CPL: begin
                            n_kind    = EV_ABS;
                            n_arg_one = (row_w >= cnt) ? (row_w - cnt) : '0;
                        end
                        FIN_CHA: begin
                            n_kind    = EV_ABS;
                            n_arg_one = row_w;
                            n_arg_two = cnt - ArgW'(1);
                        end
                        FIN_EL: begin
                            if (i_cmd.p0 == ArgW'(0)) begin
                                n_kind = EV_EOL;
                            end else if (i_cmd.p0 == ArgW'(1)) begin
                                n_kind = EV_BOL;
                            end else if (i_cmd.p0 == ArgW'(2)) begin
                                n_kind = EV_LINE;
                            end
                        end
                        FIN_ED: begin
                            if (i_cmd.p0 == ArgW'(2)) begin
                                n_kind = EV_SCREEN;
                            end else if (i_cmd.p0 == ArgW'(1)) begin
                                n_kind = EV_BOS;
                            end else begin
                                n_kind = EV_EOS;
                            end
                        end
                        FIN_STB: begin
                            if (top_s < bot) begin
                                n_kind    = EV_REGION;
                                n_arg_one = top_s[ArgW-1:0];
                                n_arg_two = bot[ArgW-1:0];
                            end
                        end
                        FIN_VPA: begin
                            n_kind    = EV_ROWABS;
                            n_arg_one = cnt - ArgW'(1);
                        end
                        FIN_ECH: begin
                            n_kind    = EV_ECH;
                            n_arg_one = cnt;
                        end
                        default: n_kind = EV_CONSUMED;
                    endcase
                end
            end
            default: n_kind = EV_CONSUMED;
        endcase
    end

    assign o_pop     = i_cmd_valid && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_arg_one = r_arg_one;
    assign o_arg_two = r_arg_two;
    assign o_cp      = r_cp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= ROWS_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rows <= i_cfg_data;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind    <= n_kind;
            r_arg_one <= n_arg_one;
            r_arg_two <= n_arg_two;
            r_cp      <= n_cp;
        end
    end

endmodule

>>> rtl/vt100_escape_sequence_parser_unit.sv
// One terminal byte is taken per cycle while o_ready is high; every byte gives
// exactly one event, in order. The front part updates the escape, control-sequence,
// command-string, charset and utf-8 state in the cycle that a byte is transferred and
// writes a classified command into a two-entry queue; the back part decodes it and holds
// the event in an output register. An event goes through a queue slot, then the output
// register. The sustained rate is one byte per cycle while the output side takes one
// event per cycle; the queue sets how far the input side can run on while the output
// stalls. screen_rows is written through i_cfg_we and i_cfg_data and resets to 24.
// ----------------------------------------------------------------------------
// vt100_escape_sequence_parser_unit
// Top level of the terminal byte-stream parser: front end, command queue and
// back end with its output register.
// ----------------------------------------------------------------------------
module vt100_escape_sequence_parser_unit import vtp_pkg::*; #(
    parameter int unsigned MAX_PARAMS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [RowW-1:0]  i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_in_byte,
    input  logic [RowW-1:0]  i_cur_row,
    input  logic [ColW-1:0]  i_cur_col,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [KindW-1:0] o_event_kind,
    output logic [ArgW-1:0]  o_arg_one,
    output logic [ArgW-1:0]  o_arg_two,
    output logic [CpW-1:0]   o_code_point
);

    logic take;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    assign o_ready = !q_full;
    assign take    = i_valid && !q_full;

    vtp_front #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in_byte),
        .i_row   (i_cur_row),
        .i_col   (i_cur_col),
        .o_cmd   (front_cmd)
    );

    vtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    vtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_event_kind),
        .o_arg_one   (o_arg_one),
        .o_arg_two   (o_arg_two),
        .o_cp        (o_code_point)
    );

endmodule
